FILE: rtl/ubx_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// UBX deframer assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef UBX_FRAME_DEFRAMER_DEFINES_SVH
`define UBX_FRAME_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check prop on every clock edge outside reset.
`define UFD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ubx_frame_deframer assertion failed");

// Check that cons holds in the cycle after ante.
`define UFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ubx_frame_deframer assertion failed");

`else

`define UFD_ASSERT(label, clk, rst, prop)
`define UFD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared constants and types of the UBX frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ufd_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_CLASS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_LENGTH = 8'd3;

  // Event codes
  localparam logic [1:0] EV_DATA  = 2'd0;
  localparam logic [1:0] EV_GOOD  = 2'd1;
  localparam logic [1:0] EV_CKERR = 2'd2;
  localparam logic [1:0] EV_OVER  = 2'd3;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic        is_match;
    logic [31:0] good_count;
    logic [31:0] error_count;
    logic [31:0] oversize_count;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/ufd_channels.sv
// ----------------------------------------------------------------------------
// ufd channel interfaces
// Valid/ready channels for received bytes, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [7:0]  frame_class;
  logic [7:0]  frame_id;
  logic [15:0] frame_length;
  logic        is_match;
  logic [31:0] good_count;
  logic [31:0] error_count;
  logic [31:0] oversize_count;

  modport source (output valid, output event_res, output data_byte, output byte_index,
                  output frame_class, output frame_id, output frame_length,
                  output is_match, output good_count, output error_count,
                  output oversize_count, input ready);
  modport sink   (input valid, input event_res, input data_byte, input byte_index,
                  input frame_class, input frame_id, input frame_length,
                  input is_match, input good_count, input error_count,
                  input oversize_count, output ready);
endinterface

interface ufd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ufd_pkg::CFG_IDX_W-1:0]   index;
  logic [ufd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ubx_frame_deframer.sv
// ----------------------------------------------------------------------------
// ubx_frame_deframer
// UBX frame parser with Fletcher-8 check, cut-through payload and counters.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                      transaction
//  -------  ---  -------------------------------------------  -------------------
//  rx       in   rx_byte                                      one stream byte
//  res      out  event_res, data_byte, byte_index, class, id, zero or one per byte
//                length, is_match, three frame counters
//  cfg      in   index, data                                  one register write
//
//  Each byte is parsed in the cycle it is accepted: one compare and two 8-bit
//  adds set the parser state, and its result is registered in the output
//  register, or in the skid register if the output stalls. One byte per cycle is
//  sustained; rx stalls only while output and skid registers hold unread results.
//  rst is synchronous and restores registers and parser to the hunt for sync.
//  cfg is always ready and takes effect at the next byte.
//
`default_nettype none

`include "ubx_frame_deframer_defines.svh"

module ubx_frame_deframer (
  input  wire logic  clk,
  input  wire logic  rst,
  ufd_byte_if.sink   rx,
  ufd_res_if.source  res,
  ufd_cfg_if.sink    cfg
);

  // Parser phases
  localparam logic [3:0] PH_SYNC1 = 4'd0;
  localparam logic [3:0] PH_SYNC2 = 4'd1;
  localparam logic [3:0] PH_CLASS = 4'd2;
  localparam logic [3:0] PH_ID    = 4'd3;
  localparam logic [3:0] PH_LEN1  = 4'd4;
  localparam logic [3:0] PH_LEN2  = 4'd5;
  localparam logic [3:0] PH_PAY   = 4'd6;
  localparam logic [3:0] PH_CKA   = 4'd7;
  localparam logic [3:0] PH_CKB   = 4'd8;

  // Configuration registers
  logic [15:0] max_payload;
  logic [7:0]  match_class;
  logic [7:0]  match_id;
  logic [15:0] match_length;

  // Parser state
  logic [3:0]  parse_phase, parse_phase_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  cur_class, cur_class_next;
  logic [7:0]  cur_id, cur_id_next;
  logic [15:0] cur_length, cur_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic        too_long, too_long_next;
  logic [31:0] ok_frames, ok_frames_next;
  logic [31:0] bad_frames, bad_frames_next;
  logic [31:0] long_frames, long_frames_next;

  // Output register and skid register
  logic              out_valid, out_valid_next;
  logic              skid_valid, skid_valid_next;
  ufd_pkg::res_t     out_data;
  ufd_pkg::res_t     skid_data;

  logic              in_acc;
  logic              pop;
  logic              res_valid;
  logic [1:0]        res_event;
  logic [7:0]        res_byte;
  logic [15:0]       res_index;
  logic              res_match;
  ufd_pkg::res_t     res_item;
  logic [7:0]        b;
  logic [7:0]        acc_a;
  logic [7:0]        acc_b;
  logic [15:0]       len_full;
  logic [15:0]       seen_inc;

  assign rx.ready  = !skid_valid;
  assign cfg.ready = 1'b1;
  assign in_acc    = rx.valid && rx.ready;
  assign pop       = out_valid && res.ready;

  assign b        = rx.rx_byte;
  assign acc_a    = sum_a + b;
  assign acc_b    = sum_b + acc_a;
  assign len_full = {b, cur_length[7:0]};
  assign seen_inc = bytes_seen + 16'd1;

  // Parse one byte: next state and the result it causes
  always_comb begin
    parse_phase_next = parse_phase;
    sum_a_next       = sum_a;
    sum_b_next       = sum_b;
    cur_class_next   = cur_class;
    cur_id_next      = cur_id;
    cur_length_next  = cur_length;
    bytes_seen_next  = bytes_seen;
    too_long_next    = too_long;
    ok_frames_next   = ok_frames;
    bad_frames_next  = bad_frames;
    long_frames_next = long_frames;
    res_valid        = 1'b0;
    res_event        = ufd_pkg::EV_DATA;
    res_byte         = 8'd0;
    res_index        = 16'd0;
    res_match        = 1'b0;
    case (parse_phase)
      PH_SYNC2: begin
        if (b == ufd_pkg::SYNC_SECOND) begin
          sum_a_next       = 8'd0;
          sum_b_next       = 8'd0;
          parse_phase_next = PH_CLASS;
        end else if (b != ufd_pkg::SYNC_FIRST) begin
          parse_phase_next = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        cur_class_next   = b;
        sum_a_next       = acc_a;
        sum_b_next       = acc_b;
        parse_phase_next = PH_ID;
      end
      PH_ID: begin
        cur_id_next      = b;
        sum_a_next       = acc_a;
        sum_b_next       = acc_b;
        parse_phase_next = PH_LEN1;
      end
      PH_LEN1: begin
        cur_length_next  = {8'd0, b};
        sum_a_next       = acc_a;
        sum_b_next       = acc_b;
        parse_phase_next = PH_LEN2;
      end
      PH_LEN2: begin
        cur_length_next  = len_full;
        sum_a_next       = acc_a;
        sum_b_next       = acc_b;
        bytes_seen_next  = 16'd0;
        too_long_next    = len_full > max_payload;
        // Zero length skips straight to the checksum
        parse_phase_next = (len_full == 16'd0) ? PH_CKA : PH_PAY;
        if (len_full > max_payload) begin
          long_frames_next = long_frames + 32'd1;
          res_valid        = 1'b1;
          res_event        = ufd_pkg::EV_OVER;
        end
      end
      PH_PAY: begin
        sum_a_next      = acc_a;
        sum_b_next      = acc_b;
        bytes_seen_next = seen_inc;
        if (seen_inc >= cur_length) begin
          parse_phase_next = PH_CKA;
        end
        // Stream the byte unless the frame is being dropped
        if (!too_long) begin
          res_valid = 1'b1;
          res_event = ufd_pkg::EV_DATA;
          res_byte  = b;
          res_index = bytes_seen;
        end
      end
      PH_CKA: begin
        if (b == sum_a) begin
          parse_phase_next = PH_CKB;
        end else begin
          // First checksum byte wrong: report and restart the hunt
          bad_frames_next  = bad_frames + 32'd1;
          parse_phase_next = PH_SYNC1;
          res_valid        = 1'b1;
          res_event        = ufd_pkg::EV_CKERR;
        end
      end
      PH_CKB: begin
        parse_phase_next = PH_SYNC1;
        if (b == sum_b) begin
          if (!too_long) begin
            ok_frames_next = ok_frames + 32'd1;
            res_valid      = 1'b1;
            res_event      = ufd_pkg::EV_GOOD;
            res_match      = (cur_class == match_class) && (cur_id == match_id) &&
                             (cur_length == match_length);
          end
        end else begin
          bad_frames_next = bad_frames + 32'd1;
          res_valid       = 1'b1;
          res_event       = ufd_pkg::EV_CKERR;
        end
      end
      default: begin
        // Hunt for the first sync byte; unused codes land here too
        parse_phase_next = (b == ufd_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  always_comb begin
    res_item.event_res      = res_event;
    res_item.data_byte      = res_byte;
    res_item.byte_index     = res_index;
    res_item.frame_class    = cur_class_next;
    res_item.frame_id       = cur_id_next;
    res_item.frame_length   = cur_length_next;
    res_item.is_match       = res_match;
    res_item.good_count     = ok_frames_next;
    res_item.error_count    = bad_frames_next;
    res_item.oversize_count = long_frames_next;
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload  <= 16'd256;
      match_class  <= 8'd1;
      match_id     <= 8'd7;
      match_length <= 16'd92;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        ufd_pkg::REG_MAX_PAYLOAD:  max_payload  <= cfg.data;
        ufd_pkg::REG_MATCH_CLASS:  match_class  <= cfg.data[7:0];
        ufd_pkg::REG_MATCH_ID:     match_id     <= cfg.data[7:0];
        ufd_pkg::REG_MATCH_LENGTH: match_length <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Advance the parser on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_SYNC1;
      sum_a       <= 8'd0;
      sum_b       <= 8'd0;
      cur_class   <= 8'd0;
      cur_id      <= 8'd0;
      cur_length  <= 16'd0;
      bytes_seen  <= 16'd0;
      too_long    <= 1'b0;
      ok_frames   <= 32'd0;
      bad_frames  <= 32'd0;
      long_frames <= 32'd0;
    end else if (in_acc) begin
      parse_phase <= parse_phase_next;
      sum_a       <= sum_a_next;
      sum_b       <= sum_b_next;
      cur_class   <= cur_class_next;
      cur_id      <= cur_id_next;
      cur_length  <= cur_length_next;
      bytes_seen  <= bytes_seen_next;
      too_long    <= too_long_next;
      ok_frames   <= ok_frames_next;
      bad_frames  <= bad_frames_next;
      long_frames <= long_frames_next;
    end
  end

  // Output register with skid: the skid catches a result while the output stalls
  always_comb begin
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    if (pop) begin
      out_valid_next  = skid_valid;
      skid_valid_next = 1'b0;
    end
    if (in_acc && res_valid) begin
      if (!out_valid || pop) begin
        out_valid_next = 1'b1;
      end else begin
        skid_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (in_acc && res_valid && (!out_valid || pop)) begin
      out_data <= res_item;
    end
    if (in_acc && res_valid && out_valid && !pop) begin
      skid_data <= res_item;
    end
  end

  assign res.valid          = out_valid;
  assign res.event_res      = out_data.event_res;
  assign res.data_byte      = out_data.data_byte;
  assign res.byte_index     = out_data.byte_index;
  assign res.frame_class    = out_data.frame_class;
  assign res.frame_id       = out_data.frame_id;
  assign res.frame_length   = out_data.frame_length;
  assign res.is_match       = out_data.is_match;
  assign res.good_count     = out_data.good_count;
  assign res.error_count    = out_data.error_count;
  assign res.oversize_count = out_data.oversize_count;

  // Assertions
  `UFD_ASSERT(a_skid_needs_out, clk, rst, !skid_valid || out_valid)
  `UFD_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !res.ready && skid_valid,
                   out_valid && skid_valid)
  `UFD_ASSERT(a_index_in_frame, clk, rst,
              !(out_valid && out_data.event_res == ufd_pkg::EV_DATA) ||
              (out_data.byte_index < out_data.frame_length))
  `UFD_ASSERT_NEXT(a_good_only_on_event, clk, rst,
                   !(in_acc && res_valid && res_event == ufd_pkg::EV_GOOD),
                   ok_frames == $past(ok_frames))
  `UFD_ASSERT(a_match_only_good, clk, rst,
              !(out_valid && out_data.is_match) ||
              (out_data.event_res == ufd_pkg::EV_GOOD))

endmodule

`default_nettype wire
